// ----- rtl/circular_deque_unit_assert.svh -----
// assertion macros for the circular deque unit
`ifndef CIRCULAR_DEQUE_UNIT_ASSERT_SVH
`define CIRCULAR_DEQUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked only outside reset
`define CDQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// property checked on every edge, reset included
`define CDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDQ_ASSERT(lbl, clk, rstn, prop, msg)
`define CDQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/cdq_pkg.sv -----
// shared types, codes and constants of the circular deque unit
package cdq_pkg;

    // default sizes
    localparam int DEF_DEPTH      = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // fixed field widths
    localparam int FUNC_W = 3;
    localparam int CAP_W  = 5;

    // operation codes, anything else is a peek
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;

    // controller to datapath commands
    typedef struct packed {
        logic take;   // latch the input word
        logic prep;   // load the wrap remainder
        logic step;   // one subtract of the wrap remainder
        logic exec;   // update ends, count and store
        logic read;   // read both end slots
        logic load;   // fill the output register
    } cdq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic mod_done;  // remainder below capacity
        logic out_free;  // output register can take a word
    } cdq_stat_t;

endpackage

// ----- rtl/cdq_ctrl.sv -----
// sequencing state machine of the circular deque unit
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  cdq_stat_t stat,
    output cdq_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_MOD  = 6'b000100,
        S_EXEC = 6'b001000,
        S_READ = 6'b010000,
        S_LOAD = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_MOD;
            end
            S_MOD: begin
                if (stat.mod_done) begin
                    state_next = S_EXEC;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/cdq_dpath.sv -----
// ring store, end pointers, wrap unit and output register of the deque
module cdq_dpath
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cdq_cmd_t              cmd,
    output cdq_stat_t             stat,
    input  logic [FUNC_W-1:0]     in_func,
    input  logic [DATA_WIDTH-1:0] in_value,
    input  logic                  cfg_we,
    input  logic [CAP_W-1:0]      cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  out_ok,
    output logic [DATA_WIDTH-1:0] out_front,
    output logic [DATA_WIDTH-1:0] out_rear,
    output logic                  out_empty,
    output logic                  out_full,
    output logic [CAP_W-1:0]      out_occ
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int REM_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
    localparam int CAP_LIMIT = (DEPTH > 31) ? 31 : DEPTH;
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(CAP_LIMIT);

    logic [FUNC_W-1:0]     func_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [CAP_W-1:0]      cap_reg;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [IDX_W-1:0]      rear_reg, rear_next;
    logic [CAP_W-1:0]      count_reg, count_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic                  ok_reg, ok_next;
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_front_reg, rd_rear_reg;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;

    logic                  out_valid_reg;
    logic                  out_ok_reg;
    logic [DATA_WIDTH-1:0] out_front_reg;
    logic [DATA_WIDTH-1:0] out_rear_reg;
    logic                  out_empty_reg;
    logic                  out_full_reg;
    logic [CAP_W-1:0]      out_occ_reg;

    logic [CAP_W-1:0] cap_eff;
    logic [REM_W-1:0] cap_ext;
    logic             full, empty, is_push, is_pop;

    // effective capacity: zero acts as one, clipped to the store size
    always_comb begin
        priority if (cap_reg == '0) begin
            cap_eff = CAP_W'(1);
        end else if (cap_reg > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end else begin
            cap_eff = cap_reg;
        end
    end

    assign cap_ext = REM_W'(cap_eff);
    assign full    = count_reg >= cap_eff;
    assign empty   = count_reg == '0;
    assign is_push = (func_reg == FN_PUSH_FRONT) || (func_reg == FN_PUSH_BACK);
    assign is_pop  = (func_reg == FN_POP_FRONT) || (func_reg == FN_POP_BACK);

    // wrap remainder: load the stepped index, then subtract capacity until below it
    always_comb begin
        rem_next = rem_reg;
        if (cmd.prep) begin
            unique case (func_reg)
                FN_PUSH_FRONT: rem_next = REM_W'(front_reg) + cap_ext - REM_W'(1);
                FN_PUSH_BACK:  rem_next = REM_W'(rear_reg) + REM_W'(1);
                FN_POP_FRONT:  rem_next = REM_W'(front_reg) + REM_W'(1);
                FN_POP_BACK:   rem_next = REM_W'(rear_reg) + cap_ext - REM_W'(1);
                default:       rem_next = '0;
            endcase
        end else if (cmd.step) begin
            rem_next = rem_reg - cap_ext;
        end
    end

    // end pointers, count and slot write
    always_comb begin
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        ok_next    = ok_reg;
        wr_en      = 1'b0;
        wr_idx     = rem_reg[IDX_W-1:0];
        if (cmd.exec) begin
            ok_next = 1'b1;
            priority if (is_push) begin
                if (full) begin
                    ok_next = 1'b0;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CAP_W'(1);
                    priority if (empty) begin
                        front_next = '0;
                        rear_next  = '0;
                        wr_idx     = '0;
                    end else if (func_reg == FN_PUSH_FRONT) begin
                        front_next = rem_reg[IDX_W-1:0];
                    end else begin
                        rear_next = rem_reg[IDX_W-1:0];
                    end
                end
            end else if (is_pop) begin
                if (empty) begin
                    ok_next = 1'b0;
                end else begin
                    count_next = count_reg - CAP_W'(1);
                    priority if (count_reg == CAP_W'(1)) begin
                        front_next = '0;
                        rear_next  = '0;
                    end else if (func_reg == FN_POP_FRONT) begin
                        front_next = rem_reg[IDX_W-1:0];
                    end else begin
                        rear_next = rem_reg[IDX_W-1:0];
                    end
                end
            end else begin
                ok_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAP_MAX;
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_data;
            end
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
        end
    end

    // item payload and wrap remainder
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            func_reg <= in_func;
            val_reg  <= in_value;
        end
        rem_reg <= rem_next;
        ok_reg  <= ok_next;
    end

    // ring store write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= val_reg;
        end
    end

    // ring store reads at both ends
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rd_front_reg <= mem[front_reg];
            rd_rear_reg  <= mem[rear_reg];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_ok_reg    <= ok_reg;
            out_front_reg <= empty ? '1 : rd_front_reg;
            out_rear_reg  <= empty ? '1 : rd_rear_reg;
            out_empty_reg <= empty;
            out_full_reg  <= full;
            out_occ_reg   <= count_reg;
        end
    end

    assign stat.mod_done = rem_reg < cap_ext;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_ok    = out_ok_reg;
    assign out_front = out_front_reg;
    assign out_rear  = out_rear_reg;
    assign out_empty = out_empty_reg;
    assign out_full  = out_full_reg;
    assign out_occ   = out_occ_reg;

endmodule

// ----- rtl/circular_deque_unit.sv -----
// top level of the circular deque unit
//
//  channel  direction  handshake            contents
//  s_       in         s_tvalid / s_tready  func, push_value
//  m_       out        m_tvalid / m_tready  ok, front, rear, empty, full, occupancy
//  cfg_     in         cfg_valid/cfg_ready  capacity_in_use
//
// a word is taken in idle and its result is loaded after the prep, wrap, exec,
// read and load steps, one wrap step per capacity subtract (none for peeks, up
// to the store depth when capacity is one). no new word is taken until its
// result is loaded. a stalled m_tready holds the unit in its load step. reset
// clears pointers, count and output valid; capacity resets to the store size.
// store contents are not cleared.
`include "circular_deque_unit_assert.svh"

module circular_deque_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    // [2:0] func, [DATA_WIDTH+2:3] push_value, rest zero padding
    input  logic [((FUNC_W + DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // [0] ok, front_value, rear_value, is_empty, is_full, occupancy, zero padding
    output logic [((2 * DATA_WIDTH + 3 + CAP_W + 7) / 8) * 8-1:0] m_tdata,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    input  logic [CAP_W-1:0]                               cfg_data,
    input  logic                                           cfg_valid,
    output logic                                           cfg_ready
);

    localparam int M_TDATA_W = ((2 * DATA_WIDTH + 3 + CAP_W + 7) / 8) * 8;
    localparam int OCC_LSB   = 2 * DATA_WIDTH + 3;
    localparam int EMPTY_BIT = 2 * DATA_WIDTH + 1;
    localparam int CAP_LIMIT = (DEPTH > 31) ? 31 : DEPTH;

    cdq_cmd_t              cmd;
    cdq_stat_t             stat;
    logic                  out_ok, out_empty, out_full;
    logic [DATA_WIDTH-1:0] out_front, out_rear;
    logic [CAP_W-1:0]      out_occ;

    cdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cdq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_func   (s_tdata[FUNC_W-1:0]),
        .in_value  (s_tdata[FUNC_W +: DATA_WIDTH]),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_ok    (out_ok),
        .out_front (out_front),
        .out_rear  (out_rear),
        .out_empty (out_empty),
        .out_full  (out_full),
        .out_occ   (out_occ)
    );

    // capacity register takes a word at any time
    assign cfg_ready = 1'b1;

    // result word packing, lowest field first
    assign m_tdata = M_TDATA_W'({out_occ, out_full, out_empty, out_rear, out_front, out_ok});

    // checks
    `CDQ_ASSERT(a_one_in_flight, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "second word taken while one is in flight")
    `CDQ_ASSERT(a_load_shows, aclk, aresetn, cmd.load |=> m_tvalid, "loaded result not presented")
    `CDQ_ASSERT(a_occ_bound, aclk, aresetn, m_tvalid |-> (m_tdata[OCC_LSB +: CAP_W] <= CAP_W'(CAP_LIMIT)), "occupancy above store size")
    `CDQ_ASSERT(a_empty_view, aclk, aresetn, (m_tvalid && m_tdata[EMPTY_BIT]) |-> (m_tdata[OCC_LSB +: CAP_W] == '0), "empty flag with nonzero occupancy")
    `CDQ_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

// ----- dv/cdq_checker.sv -----
// watches the deque unit channels, predicts every result word and compares it
`timescale 1ns / 1ps

module cdq_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int S_W        = 40,
    parameter int M_W        = 72
) (
    input  logic             aclk,
    input  logic             aresetn,
    // [2:0] func, [DATA_WIDTH+2:3] push_value, rest zero padding
    input  logic [S_W-1:0]   s_tdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    // [0] ok, front_value, rear_value, is_empty, is_full, occupancy
    input  logic [M_W-1:0]   m_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [CAP_W-1:0] cfg_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    output int               fail_count,
    output int               pending_words,
    output int               words_checked,
    output int               refused_ops,
    output int               cfg_writes
);

    // bit positions inside the result word
    localparam int FRONT_LSB = 1;
    localparam int REAR_LSB  = 1 + DATA_WIDTH;
    localparam int EMPTY_BIT = 1 + 2 * DATA_WIDTH;
    localparam int FULL_BIT  = 2 + 2 * DATA_WIDTH;
    localparam int OCC_LSB   = 3 + 2 * DATA_WIDTH;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic                         ok;
        logic signed [DATA_WIDTH-1:0] front_val;
        logic signed [DATA_WIDTH-1:0] rear_val;
        logic                         empty;
        logic                         full;
        logic [CAP_W-1:0]             occ;
    } deque_view_t;

    // shadow copy of the deque
    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
    int unsigned           head_idx;
    int unsigned           tail_idx;
    int unsigned           fill_level;
    logic [CAP_W-1:0]      cap_setting;
    deque_view_t           view_q[$];

    // capacity actually used for wrapping
    function automatic int unsigned wrap_cap();
        if (cap_setting == '0) begin
            return 1;
        end
        if (cap_setting > DEPTH) begin
            return DEPTH;
        end
        return cap_setting;
    endfunction

    function automatic void clear_deque();
        for (int i = 0; i < DEPTH; i++) begin
            ring_mem[i] = '0;
        end
        head_idx    = 0;
        tail_idx    = 0;
        fill_level  = 0;
        cap_setting = CAP_W'(DEPTH);
    endfunction

    // apply one operation to the shadow deque and return the view after it
    function automatic deque_view_t apply_op(logic [FUNC_W-1:0] fn,
                                             logic [DATA_WIDTH-1:0] val);
        int unsigned cap;
        deque_view_t v;
        cap  = wrap_cap();
        v.ok = 1'b1;
        case (fn)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (fill_level >= cap) begin
                    v.ok = 1'b0;
                end else begin
                    if (fill_level == 0) begin
                        head_idx = 0;
                        tail_idx = 0;
                    end else if (fn == FN_PUSH_FRONT) begin
                        head_idx = (head_idx + cap - 1) % cap;
                    end else begin
                        tail_idx = (tail_idx + 1) % cap;
                    end
                    ring_mem[((fn == FN_PUSH_FRONT) ? head_idx : tail_idx) % DEPTH] = val;
                    fill_level++;
                end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
                if (fill_level == 0) begin
                    v.ok = 1'b0;
                end else begin
                    if (fill_level == 1) begin
                        head_idx = 0;
                        tail_idx = 0;
                    end else if (fn == FN_POP_FRONT) begin
                        head_idx = (head_idx + 1) % cap;
                    end else begin
                        tail_idx = (tail_idx + cap - 1) % cap;
                    end
                    fill_level--;
                end
            end
            default: begin
            end
        endcase
        v.empty     = (fill_level == 0);
        v.full      = (fill_level >= cap);
        v.front_val = v.empty ? '1 : ring_mem[head_idx % DEPTH];
        v.rear_val  = v.empty ? '1 : ring_mem[tail_idx % DEPTH];
        v.occ       = CAP_W'(fill_level);
        return v;
    endfunction

    // compare one result word with the oldest prediction
    task automatic check_word(input logic [M_W-1:0] word);
        deque_view_t want;
        deque_view_t got;
        got.ok        = word[0];
        got.front_val = word[FRONT_LSB +: DATA_WIDTH];
        got.rear_val  = word[REAR_LSB +: DATA_WIDTH];
        got.empty     = word[EMPTY_BIT];
        got.full      = word[FULL_BIT];
        got.occ       = word[OCC_LSB +: CAP_W];
        if (view_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN) begin
                $display("%0t: result word %h with no prediction waiting", $realtime, word);
            end
            return;
        end
        want = view_q.pop_front();
        words_checked++;
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN) begin
                $display("%0t: mismatch on word %0d", $realtime, words_checked);
                $display("  expected ok=%0d front=%0d rear=%0d empty=%0d full=%0d occ=%0d",
                         want.ok, want.front_val, want.rear_val, want.empty, want.full,
                         want.occ);
                $display("  actual   ok=%0d front=%0d rear=%0d empty=%0d full=%0d occ=%0d",
                         got.ok, got.front_val, got.rear_val, got.empty, got.full, got.occ);
            end
        end
    endtask

    // sample all three channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_deque();
            view_q.delete();
            fail_count    = 0;
            words_checked = 0;
            refused_ops   = 0;
            cfg_writes    = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_setting = cfg_data;
                cfg_writes++;
            end
            if (s_tvalid && s_tready) begin
                view_q.insert(view_q.size(),
                              apply_op(s_tdata[FUNC_W-1:0], s_tdata[FUNC_W +: DATA_WIDTH]));
                if (!view_q[$].ok) begin
                    refused_ops++;
                end
            end
            if (m_tvalid && m_tready) begin
                check_word(m_tdata);
            end
        end
        pending_words = view_q.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// top of the deque unit testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import cdq_pkg::*;

    localparam int DEPTH      = DEF_DEPTH;
    localparam int DW         = DEF_DATA_WIDTH;
    localparam int S_TDATA_W  = ((FUNC_W + DW + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((3 + 2 * DW + CAP_W + 7) / 8) * 8;
    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 170;
    localparam int SETTLE     = 70;

    // codes that only look at the deque
    localparam logic [FUNC_W-1:0] FN_PEEK_LO = 3'd4;
    localparam logic [FUNC_W-1:0] FN_PEEK_HI = 3'd7;

    // capacity plan, zero and values above the store size included
    localparam logic [CAP_W-1:0] CAP_PLAN [8] = '{5'd4, 5'd0, 5'd31, 5'd1,
                                                  5'd16, 5'd2, 5'd17, 5'd9};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    // [2:0] func, [34:3] push_value, [39:35] zero padding
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // [0] ok, [32:1] front_value, [64:33] rear_value, [65] is_empty, [66] is_full,
    // [71:67] occupancy
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [CAP_W-1:0]     cfg_data  = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;

    int fail_count;
    int pending_words;
    int words_checked;
    int refused_ops;
    int cfg_writes;

    bit quiet_run = 1'b0;
    int stall_left = 0;

    always #5 aclk = ~aclk;

    circular_deque_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DW)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    cdq_checker #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DW),
        .S_W        (S_TDATA_W),
        .M_W        (M_TDATA_W)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .words_checked (words_checked),
        .refused_ops   (refused_ops),
        .cfg_writes    (cfg_writes)
    );

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_run || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // push values: mostly random, sometimes the signed extremes
    function automatic logic [DW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(DW-1){1'b1}}};
            1:       return {1'b1, {(DW-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return DW'($urandom);
        endcase
    endfunction

    // result side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            m_tready <= (stall_left == 0);
        end
    end

    // offer one word and wait for it to be taken
    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [DW-1:0] val);
        int gap;
        @(negedge aclk);
        s_tdata  <= S_TDATA_W'({val, fn});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // stop offering and wait until every result word is back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_words != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge aclk);
        cfg_data  <= cap;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random word with a phase-dependent lean toward pushes or pops
    task automatic send_random_word(input int push_pct);
        int r;
        logic [FUNC_W-1:0] fn;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            fn = FUNC_W'($urandom_range(FN_PEEK_LO, FN_PEEK_HI));
        end else if (r < 10 + push_pct) begin
            fn = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
        end else begin
            fn = $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
        end
        send_word(fn, pick_value());
    endtask

    // run limit
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus and verdict
    initial begin
        logic [DW-1:0] edge_vals [4];
        logic [CAP_W-1:0] cap;
        int push_pct;
        edge_vals = '{{1'b0, {(DW-1){1'b1}}}, {1'b1, {(DW-1){1'b0}}}, '0, '1};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_capacity(CAP_W'(DEPTH));

        // empty deque: peek and refused pops
        send_word(FN_PEEK_LO, pick_value());
        send_word(FN_POP_FRONT, pick_value());
        send_word(FN_POP_BACK, pick_value());
        // fill every slot from both ends, so no end can later land on a blank slot
        for (int i = 0; i < DEPTH; i++) begin
            send_word((i % 2) ? FN_PUSH_FRONT : FN_PUSH_BACK,
                      (i < 4) ? edge_vals[i] : DW'($urandom));
        end
        // refused pushes when full, then all peek codes and both pops
        send_word(FN_PUSH_FRONT, pick_value());
        send_word(FN_PUSH_BACK, pick_value());
        for (int f = FN_PEEK_LO; f <= FN_PEEK_HI; f++) begin
            send_word(FUNC_W'(f), pick_value());
        end
        send_word(FN_POP_FRONT, pick_value());
        send_word(FN_POP_BACK, pick_value());
        drain_results();

        // random phases; the first one shrinks capacity while entries are held
        for (int p = 0; p < PHASES; p++) begin
            cap = (p < 8) ? CAP_PLAN[p] : CAP_W'($urandom_range(0, 31));
            write_capacity(cap);
            quiet_run = (p % 4 == 3);
            case ($urandom_range(0, 2))
                0:       push_pct = 60;
                1:       push_pct = 45;
                default: push_pct = 30;
            endcase
            for (int n = 0; n < PHASE_LEN; n++) begin
                send_random_word(push_pct);
            end
            drain_results();
        end
        quiet_run = 1'b0;

        repeat (SETTLE) @(negedge aclk);
        $display("%0d result words checked, %0d of them refused pushes or pops",
                 words_checked, refused_ops);
        $display("%0d capacity writes, from zero through values past the store size",
                 cfg_writes);
        if (fail_count == 0 && pending_words == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- circular_deque_unit.f -----
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_dpath.sv
rtl/circular_deque_unit.sv
dv/cdq_checker.sv
dv/tb_top.sv
